[src/sgnc_pkg.sv]
// Package of shared constants, register codes and helper functions for the grid node converter.
`default_nettype none
package sgnc_pkg;

    localparam int INDEX_BITS_DEF    = 10;
    localparam int CORDIC_STAGES_DEF = 20;

    localparam int PI_Q20      = 3294199;
    localparam int TWO_PI_Q20  = 6588397;
    localparam int HALF_PI_Q20 = 1647099;

    // Width of the CORDIC datapath, Q30 with headroom.
    localparam int CW = 34;
    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(32'sh26DD3B6A);

    localparam logic        RST_PATCH   = 1'b0;
    localparam logic [31:0] RST_RSTART  = 32'h0;
    localparam logic [31:0] RST_RSTEP   = 32'h0;
    localparam logic [23:0] RST_PSTART  = 24'd823550;
    localparam logic [23:0] RST_PSTEP   = 24'h0;
    localparam logic [23:0] RST_ASTART  = 24'hDA4D07;
    localparam logic [23:0] RST_ASTEP   = 24'h0;

    typedef enum logic [2:0] {
        REG_PATCH  = 3'd0,
        REG_RSTART = 3'd1,
        REG_RSTEP  = 3'd2,
        REG_PSTART = 3'd3,
        REG_PSTEP  = 3'd4,
        REG_ASTART = 3'd5,
        REG_ASTEP  = 3'd6
    } cfg_reg_t;

    function automatic logic [31:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:  v = 32'h3243F6A8;
            1:  v = 32'h1DAC6705;
            2:  v = 32'h0FADBAFC;
            3:  v = 32'h07F56EA6;
            4:  v = 32'h03FEAB76;
            5:  v = 32'h01FFD55B;
            6:  v = 32'h00FFFAAA;
            7:  v = 32'h007FFF55;
            8:  v = 32'h003FFFEA;
            9:  v = 32'h001FFFFD;
            10: v = 32'h000FFFFF;
            11: v = 32'h0007FFFF;
            12: v = 32'h0003FFFF;
            13: v = 32'h0001FFFF;
            14: v = 32'h0000FFFF;
            15: v = 32'h00007FFF;
            16: v = 32'h00003FFF;
            17: v = 32'h00001FFF;
            18: v = 32'h00000FFF;
            19: v = 32'h000007FF;
            20: v = 32'h000003FF;
            21: v = 32'h000001FF;
            22: v = 32'h000000FF;
            23: v = 32'h0000007F;
            24: v = 32'h0000003F;
            25: v = 32'h0000001F;
            26: v = 32'h0000000F;
            27: v = 32'h00000008;
            28: v = 32'h00000004;
            29: v = 32'h00000002;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] sat_q16(input logic signed [39:0] v);
        logic [31:0] r;
        if (v > 40'sh007FFFFFFF)
            r = 32'h7FFFFFFF;
        else if (v < -40'sh0080000000)
            r = 32'h80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[src/sgnc_mod_cell.sv]
// One step of the angle reduction chain: conditional subtract of a shifted 2*pi.
`default_nettype none
module sgnc_mod_cell #(
    parameter int W     = 36,
    parameter int SHIFT = 0
) (
    input  wire logic         clk,
    input  wire logic         en,
    input  wire logic [W-1:0] mag_in,
    output logic      [W-1:0] mag_reg
);
    import sgnc_pkg::*;

    localparam logic [W-1:0] MOD_VAL = W'(TWO_PI_Q20) << SHIFT;

    logic [W-1:0] mag_next;

    always_comb
    begin
        if (mag_in >= MOD_VAL)
            mag_next = mag_in - MOD_VAL;
        else
            mag_next = mag_in;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            mag_reg <= mag_next;
    end
endmodule
`default_nettype wire

[src/sgnc_cordic_cell.sv]
// One rotation of the CORDIC chain in rotation mode.
`default_nettype none
module sgnc_cordic_cell #(
    parameter int STAGE = 0
) (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic signed [sgnc_pkg::CW-1:0] x_in,
    input  wire logic signed [sgnc_pkg::CW-1:0] y_in,
    input  wire logic signed [sgnc_pkg::CW-1:0] z_in,
    output logic signed      [sgnc_pkg::CW-1:0] x_reg,
    output logic signed      [sgnc_pkg::CW-1:0] y_reg,
    output logic signed      [sgnc_pkg::CW-1:0] z_reg
);
    import sgnc_pkg::*;

    localparam logic signed [CW-1:0] ATAN_VAL = CW'(atan_q30(STAGE));

    logic signed [CW-1:0] x_next, y_next, z_next;
    logic signed [CW-1:0] xs, ys;

    always_comb
    begin
        xs = x_in >>> STAGE;
        ys = y_in >>> STAGE;
        if (!z_in[CW-1])
        begin
            x_next = x_in - ys;
            y_next = y_in + xs;
            z_next = z_in - ATAN_VAL;
        end
        else
        begin
            x_next = x_in + ys;
            y_next = y_in - xs;
            z_next = z_in + ATAN_VAL;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end
endmodule
`default_nettype wire

[src/spherical_grid_node_coordinates.sv]
// Top level: grid node indices to Cartesian coordinates through reduction and CORDIC cell chains.
// The pipeline holds two index stages, INDEX_BITS+3 reduction cells, a fold stage, one CORDIC
// cell per rotation and five multiply and output stages.
// Throughput is one item per cycle; the whole pipeline holds only while a result waits untaken.
// rst_n clears the valid bits and loads the register defaults; data registers are not reset.
`default_nettype none
module spherical_grid_node_coordinates #(
    parameter int INDEX_BITS    = sgnc_pkg::INDEX_BITS_DEF,
    parameter int CORDIC_STAGES = sgnc_pkg::CORDIC_STAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // radial_index, latitude_index, longitude_index, zero padding
    input  wire logic [((3*INDEX_BITS+7)/8)*8-1:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // coord_x, coord_y, coord_z
    output logic [95:0]      m_tdata,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import sgnc_pkg::*;

    localparam int IB    = INDEX_BITS;
    localparam int N     = CORDIC_STAGES;
    localparam int RED   = IB + 3;
    localparam int DEPTH = RED + N + 8;
    localparam int PRW   = 33 + IB;
    localparam int RSW   = PRW + 1;
    localparam int PTW   = 25 + IB;
    localparam int AW    = PTW + 1;
    localparam int RPN   = RED + N + 2;

    localparam logic signed [RSW-1:0] R_MAX = RSW'(signed'(32'h7FFFFFFF));
    localparam logic signed [RSW-1:0] R_MIN = RSW'(signed'(32'h80000000));
    localparam logic signed [24:0] PI25   = 25'(PI_Q20);
    localparam logic signed [24:0] TWO25  = 25'(TWO_PI_Q20);
    localparam logic signed [24:0] HALF25 = 25'(HALF_PI_Q20);
    localparam logic signed [63:0] RND64  = 64'sd536870912;
    localparam logic signed [65:0] RND66  = 66'sd536870912;

    typedef struct packed {
        logic                 neg;
        logic signed [CW-1:0] z;
    } fold_t;

    function automatic fold_t fold_angle(input logic sgn, input logic [22:0] m);
        logic signed [24:0] a;
        fold_t f;
        a = sgn ? -$signed({2'b00, m}) : $signed({2'b00, m});
        f.neg = 1'b0;
        if (a > PI25)
            a = a - TWO25;
        if (a < -PI25)
            a = a + TWO25;
        if (a > HALF25)
        begin
            a = a - PI25;
            f.neg = 1'b1;
        end
        else if (a < -HALF25)
        begin
            a = a + PI25;
            f.neg = 1'b1;
        end
        f.z = CW'(a) <<< 10;
        return f;
    endfunction

    // Configuration registers
    logic        patch_reg;
    logic [31:0] rstart_reg, rstep_reg;
    logic [23:0] pstart_reg, pstep_reg, astart_reg, astep_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            patch_reg  <= RST_PATCH;
            rstart_reg <= RST_RSTART;
            rstep_reg  <= RST_RSTEP;
            pstart_reg <= RST_PSTART;
            pstep_reg  <= RST_PSTEP;
            astart_reg <= RST_ASTART;
            astep_reg  <= RST_ASTEP;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_PATCH:  patch_reg  <= cfg_data[0];
                REG_RSTART: rstart_reg <= cfg_data;
                REG_RSTEP:  rstep_reg  <= cfg_data;
                REG_PSTART: pstart_reg <= cfg_data[23:0];
                REG_PSTEP:  pstep_reg  <= cfg_data[23:0];
                REG_ASTART: astart_reg <= cfg_data[23:0];
                REG_ASTEP:  astep_reg  <= cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // Pipeline valid bits; the whole chain advances together.
    logic [DEPTH-1:0] vpipe_reg;
    logic             en;

    assign en       = !vpipe_reg[DEPTH-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vpipe_reg[DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vpipe_reg <= '0;
        else if (en)
            vpipe_reg <= {vpipe_reg[DEPTH-2:0], s_tvalid};
    end

    // Stage A: index products
    logic [IB-1:0]        idx_i, idx_j, idx_k;
    logic signed [IB:0]   i_s, jm1, km2;
    logic signed [PRW-1:0] prod_r_reg;
    logic signed [PTW-1:0] prod_t_reg, prod_p_reg;

    assign idx_i = s_tdata[IB-1:0];
    assign idx_j = s_tdata[2*IB-1:IB];
    assign idx_k = s_tdata[3*IB-1:2*IB];
    assign i_s   = $signed({1'b0, idx_i});
    assign jm1   = $signed({1'b0, idx_j}) - (IB+1)'(1);
    assign km2   = $signed({1'b0, idx_k}) - (IB+1)'(2);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_r_reg <= PRW'($signed(rstep_reg)) * PRW'(i_s);
            prod_t_reg <= PTW'($signed(pstep_reg)) * PTW'(jm1);
            prod_p_reg <= PTW'($signed(astep_reg)) * PTW'(km2);
        end
    end

    // Stage B: sums, radius saturation, angle sign and magnitude
    logic signed [RSW-1:0] rsum;
    logic signed [AW-1:0]  tsum, psum;
    logic [31:0]           r_b_reg;
    logic [AW-1:0]         tmag_b_reg, pmag_b_reg;
    logic                  tsg_b_reg, psg_b_reg;

    assign rsum = RSW'($signed(rstart_reg)) + RSW'(prod_r_reg);
    assign tsum = AW'($signed(pstart_reg)) + AW'(prod_t_reg);
    assign psum = AW'($signed(astart_reg)) + AW'(prod_p_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (rsum > R_MAX)
                r_b_reg <= 32'h7FFFFFFF;
            else if (rsum < R_MIN)
                r_b_reg <= 32'h80000000;
            else
                r_b_reg <= rsum[31:0];
            tsg_b_reg  <= tsum[AW-1];
            psg_b_reg  <= psum[AW-1];
            tmag_b_reg <= tsum[AW-1] ? AW'(-tsum) : AW'(tsum);
            pmag_b_reg <= psum[AW-1] ? AW'(-psum) : AW'(psum);
        end
    end

    // Reduction chain modulo 2*pi, largest multiple first
    logic [AW-1:0] tmag_w [RED+1];
    logic [AW-1:0] pmag_w [RED+1];
    logic          tsg_reg [RED];
    logic          psg_reg [RED];

    assign tmag_w[0] = tmag_b_reg;
    assign pmag_w[0] = pmag_b_reg;

    for (genvar k = 0; k < RED; k++)
    begin : g_red
        sgnc_mod_cell #(.W(AW), .SHIFT(RED-1-k)) u_tcell (
            .clk(clk), .en(en), .mag_in(tmag_w[k]), .mag_reg(tmag_w[k+1])
        );
        sgnc_mod_cell #(.W(AW), .SHIFT(RED-1-k)) u_pcell (
            .clk(clk), .en(en), .mag_in(pmag_w[k]), .mag_reg(pmag_w[k+1])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tsg_reg[0] <= tsg_b_reg;
            psg_reg[0] <= psg_b_reg;
            for (int k = 1; k < RED; k++)
            begin
                tsg_reg[k] <= tsg_reg[k-1];
                psg_reg[k] <= psg_reg[k-1];
            end
        end
    end

    // Radius delay line alongside the angle path
    logic [31:0] r_pipe_reg [RPN];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_pipe_reg[0] <= r_b_reg;
            for (int k = 1; k < RPN; k++)
                r_pipe_reg[k] <= r_pipe_reg[k-1];
        end
    end

    // Fold stage: into [-pi/2, pi/2] and Q30
    fold_t tfold, pfold;
    logic signed [CW-1:0] tz_f_reg, pz_f_reg;
    logic                 tneg_reg [N+1];
    logic                 pneg_reg [N+1];

    assign tfold = fold_angle(tsg_reg[RED-1], tmag_w[RED][22:0]);
    assign pfold = fold_angle(psg_reg[RED-1], pmag_w[RED][22:0]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tz_f_reg    <= tfold.z;
            pz_f_reg    <= pfold.z;
            tneg_reg[0] <= tfold.neg;
            pneg_reg[0] <= pfold.neg;
            for (int c = 1; c <= N; c++)
            begin
                tneg_reg[c] <= tneg_reg[c-1];
                pneg_reg[c] <= pneg_reg[c-1];
            end
        end
    end

    // CORDIC chains, one cell per rotation
    logic signed [CW-1:0] tx_w [N+1];
    logic signed [CW-1:0] ty_w [N+1];
    logic signed [CW-1:0] tz_w [N+1];
    logic signed [CW-1:0] px_w [N+1];
    logic signed [CW-1:0] py_w [N+1];
    logic signed [CW-1:0] pz_w [N+1];

    assign tx_w[0] = CORDIC_GAIN;
    assign ty_w[0] = '0;
    assign tz_w[0] = tz_f_reg;
    assign px_w[0] = CORDIC_GAIN;
    assign py_w[0] = '0;
    assign pz_w[0] = pz_f_reg;

    for (genvar c = 0; c < N; c++)
    begin : g_cordic
        sgnc_cordic_cell #(.STAGE(c)) u_tcell (
            .clk(clk), .en(en),
            .x_in(tx_w[c]), .y_in(ty_w[c]), .z_in(tz_w[c]),
            .x_reg(tx_w[c+1]), .y_reg(ty_w[c+1]), .z_reg(tz_w[c+1])
        );
        sgnc_cordic_cell #(.STAGE(c)) u_pcell (
            .clk(clk), .en(en),
            .x_in(px_w[c]), .y_in(py_w[c]), .z_in(pz_w[c]),
            .x_reg(px_w[c+1]), .y_reg(py_w[c+1]), .z_reg(pz_w[c+1])
        );
    end

    // Stage D: sine and cosine with the fold sign applied
    logic signed [31:0] st_reg, ct_reg, sp_reg, cp_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            st_reg <= 32'(tneg_reg[N] ? -ty_w[N] : ty_w[N]);
            ct_reg <= 32'(tneg_reg[N] ? -tx_w[N] : tx_w[N]);
            sp_reg <= 32'(pneg_reg[N] ? -py_w[N] : py_w[N]);
            cp_reg <= 32'(pneg_reg[N] ? -px_w[N] : px_w[N]);
        end
    end

    // Multiply stages
    logic signed [63:0] prs_reg, pz_reg;
    logic signed [31:0] sp1_reg, cp1_reg, sp2_reg, cp2_reg;
    logic signed [33:0] rs_reg, zr_reg, zr3_reg;
    logic signed [65:0] pxm_reg, pym_reg;
    logic signed [31:0] r_m;

    assign r_m = $signed(r_pipe_reg[RPN-1]);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prs_reg <= 64'(r_m) * 64'(st_reg);
            pz_reg  <= 64'(r_m) * 64'(ct_reg);
            sp1_reg <= sp_reg;
            cp1_reg <= cp_reg;
            rs_reg  <= 34'((prs_reg + RND64) >>> 30);
            zr_reg  <= 34'((pz_reg + RND64) >>> 30);
            sp2_reg <= sp1_reg;
            cp2_reg <= cp1_reg;
            pxm_reg <= 66'(rs_reg) * 66'(cp2_reg);
            pym_reg <= 66'(rs_reg) * 66'(sp2_reg);
            zr3_reg <= zr_reg;
        end
    end

    // Output stage: rounding, patch axis order, saturation
    logic signed [35:0] xr, yr;
    logic [31:0]        cx_reg, cy_reg, cz_reg;

    assign xr = 36'((pxm_reg + RND66) >>> 30);
    assign yr = 36'((pym_reg + RND66) >>> 30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (patch_reg)
            begin
                cx_reg <= sat_q16(40'(-xr));
                cy_reg <= sat_q16(40'(zr3_reg));
                cz_reg <= sat_q16(40'(yr));
            end
            else
            begin
                cx_reg <= sat_q16(40'(xr));
                cy_reg <= sat_q16(40'(yr));
                cz_reg <= sat_q16(40'(zr3_reg));
            end
        end
    end

    assign m_tdata = {cz_reg, cy_reg, cx_reg};

    // A waiting result is never dropped before it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result lost while stalled");

    // Input acceptance and the first valid bit agree.
    a_in_track: assert property (@(posedge clk) disable iff (!rst_n)
        en && s_tvalid |=> vpipe_reg[0])
        else $error("accepted item not tracked");

    // After the reduction chain the magnitudes are below 2*pi.
    a_red_range: assert property (@(posedge clk) disable iff (!rst_n)
        vpipe_reg[RED+1] |-> (tmag_w[RED] < AW'(TWO_PI_Q20)) && (pmag_w[RED] < AW'(TWO_PI_Q20)))
        else $error("angle reduction out of range");

    // The folded angle stays within a quarter turn.
    a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
        vpipe_reg[RED+2] |-> (tz_f_reg <= (CW'(HALF_PI_Q20) <<< 10))
                         && (tz_f_reg >= -(CW'(HALF_PI_Q20) <<< 10)))
        else $error("fold out of range");

endmodule
`default_nettype wire
